// ===== rtl/core/loop_period_jitter_statistics_unit_defines.svh =====
// Assertion macros for the loop period jitter statistics unit.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef LOOP_PERIOD_JITTER_STATISTICS_UNIT_DEFINES_SVH
`define LOOP_PERIOD_JITTER_STATISTICS_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LPJS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define LPJS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define LPJS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LPJS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lpjs_pkg.sv =====
// Shared types and constants of the loop period jitter statistics unit.
// No dependencies.
`default_nettype none
package lpjs_pkg;

    localparam int COUNT_BITS_DEF  = 24;
    localparam int PERIOD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int VALUE_BITS = 32;
    localparam int VAR_BITS   = 64;
    localparam int SC_BITS    = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [VALUE_BITS-1:0] NOMINAL_RESET      = 32'd256000;
    localparam logic [SC_BITS-1:0]    SAMPLE_COUNT_RESET = 24'd1000;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_NOMINAL = 2'd0;
    localparam t_cfg_idx CFG_COUNT   = 2'd1;

    typedef logic t_opcode;
    localparam t_opcode OP_ARM    = 1'b0;
    localparam t_opcode OP_SAMPLE = 1'b1;

    localparam int DIV_CNT_BITS = 7;
    localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_LONG  = 7'd64;
    localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_SHORT = 7'd32;

    localparam int SQRT_CNT_BITS = 6;
    localparam logic [SQRT_CNT_BITS-1:0] SQRT_STEPS = 6'd32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MEAN_DIV,
        ST_SQR,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_VAR_DIV,
        ST_VAR_ADD,
        ST_SQRT_GO,
        ST_SQRT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic half;
    } t_div_req;

endpackage
`default_nettype wire

// ===== rtl/core/lpjs_in_if.sv =====
// Input word channel: opcode and measured period with valid/ready.
// Depends on lpjs_pkg.
`default_nettype none
interface lpjs_in_if #(
    parameter int PERIOD_BITS = lpjs_pkg::PERIOD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    lpjs_pkg::t_opcode       opcode;
    logic [PERIOD_BITS-1:0]  period;

    modport source (output valid, output opcode, output period, input ready);
    modport sink   (input valid, input opcode, input period, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpjs_out_if.sv =====
// Result word channel: running statistics of one sample with valid/ready.
// Depends on lpjs_pkg.
`default_nettype none
interface lpjs_out_if #(
    parameter int COUNT_BITS = lpjs_pkg::COUNT_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [COUNT_BITS-1:0]             sample_index;
    logic [lpjs_pkg::VALUE_BITS-1:0]   mean_period;
    logic [lpjs_pkg::VALUE_BITS-1:0]   min_period;
    logic [COUNT_BITS-1:0]             min_index;
    logic [lpjs_pkg::VALUE_BITS-1:0]   max_period;
    logic [COUNT_BITS-1:0]             max_index;
    logic [lpjs_pkg::VALUE_BITS-1:0]   std_dev;
    logic                              last;

    modport source (output valid, output sample_index, output mean_period,
                    output min_period, output min_index, output max_period,
                    output max_index, output std_dev, output last, input ready);
    modport sink   (input valid, input sample_index, input mean_period,
                    input min_period, input min_index, input max_period,
                    input max_index, input std_dev, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpjs_cfg_if.sv =====
// Configuration write channel: register index and data with valid/ready.
// Depends on lpjs_pkg.
`default_nettype none
interface lpjs_cfg_if;
    logic                                 valid;
    logic                                 ready;
    lpjs_pkg::t_cfg_idx                   index;
    logic [lpjs_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpjs_div.sv =====
// Radix-2 restoring divider, 64-bit dividend, one quotient bit per cycle.
// Half mode divides a 32-bit dividend in 32 steps. Depends on lpjs_pkg.
`default_nettype none
module lpjs_div #(
    parameter int DIV_BITS = lpjs_pkg::COUNT_BITS_DEF + 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lpjs_pkg::t_div_req                  i_req,
    input  wire logic [lpjs_pkg::VAR_BITS-1:0]       i_dividend,
    input  wire logic [DIV_BITS-1:0]                 i_divisor,
    output logic                                     o_done,
    output logic [lpjs_pkg::VAR_BITS-1:0]            o_quotient
);
    logic                                  r_busy;
    logic                                  r_done;
    logic [lpjs_pkg::DIV_CNT_BITS-1:0]     r_cnt;
    logic [DIV_BITS-1:0]                   r_rem;
    logic [DIV_BITS-1:0]                   r_dvs;
    logic [lpjs_pkg::VAR_BITS-1:0]         r_quo;

    logic [DIV_BITS:0]                     w_trial;
    logic [DIV_BITS:0]                     w_sub;
    logic                                  w_ge;

    assign w_trial = {r_rem, r_quo[lpjs_pkg::VAR_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == lpjs_pkg::DIV_CNT_BITS'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.half ? lpjs_pkg::DIV_STEPS_SHORT : lpjs_pkg::DIV_STEPS_LONG;
            end else if (r_busy) begin
                r_cnt <= r_cnt - lpjs_pkg::DIV_CNT_BITS'(1);
                if (r_cnt == lpjs_pkg::DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_req.half ? {i_dividend[31:0], 32'd0} : i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DIV_BITS-1:0] : w_trial[DIV_BITS-1:0];
            r_quo <= {r_quo[lpjs_pkg::VAR_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ===== rtl/core/lpjs_sqrt.sv =====
// Bit-serial integer square root of a 64-bit value, one root bit per cycle.
// Depends on lpjs_pkg.
`default_nettype none
module lpjs_sqrt (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [lpjs_pkg::VAR_BITS-1:0]      i_operand,
    output logic                                    o_done,
    output logic [lpjs_pkg::VALUE_BITS-1:0]         o_root
);
    logic                                   r_busy;
    logic                                   r_done;
    logic [lpjs_pkg::SQRT_CNT_BITS-1:0]     r_cnt;
    logic [lpjs_pkg::VAR_BITS-1:0]          r_x;
    logic [34:0]                            r_rem;
    logic [lpjs_pkg::VALUE_BITS-1:0]        r_root;

    logic [34:0]                            w_rem_sh;
    logic [34:0]                            w_trial;
    logic                                   w_ge;

    assign w_rem_sh = {r_rem[32:0], r_x[lpjs_pkg::VAR_BITS-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == lpjs_pkg::SQRT_CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= lpjs_pkg::SQRT_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - lpjs_pkg::SQRT_CNT_BITS'(1);
                if (r_cnt == lpjs_pkg::SQRT_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[lpjs_pkg::VAR_BITS-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[lpjs_pkg::VALUE_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== rtl/core/loop_period_jitter_statistics_unit.sv =====
// Top level of the loop period jitter statistics unit: sequencer, datapath,
// configuration registers and result register. Uses lpjs_pkg, the channel
// interfaces, lpjs_div, lpjs_sqrt and the assertion macro header.
//
// Channels: i_in takes words of opcode and period; opcode arm seeds mean,
// min and max with nominal_period and restarts the run, opcode sample
// delivers one measured period. o_out gives one word per processed sample.
// i_cfg writes nominal_period (index 0) or sample_count (index 1).
// Sequencing: an arm word or an ignored sample is taken in IDLE and leaves
// the sequencer there. A processed sample passes START, MEAN_DIV, SQR,
// MUL_LO, MUL_HI, VAR_DIV and VAR_ADD, on the last sample of a run also
// SQRT_GO and SQRT, and enters the result register from DONE; the next
// word is taken back in IDLE. The work is set by the shared radix-2
// divider (32 steps for the mean, 64 for the variance) and the 32-step
// square root; i_in is not ready while a sample is in work.
// Reset: no run active, index 1, registers at 256000 and 1000.
// Stall: the result register holds a word until o_out is ready; the next
// sample is taken meanwhile and waits at its end for the register to free.
`default_nettype none
`include "loop_period_jitter_statistics_unit_defines.svh"
module loop_period_jitter_statistics_unit #(
    parameter int COUNT_BITS  = lpjs_pkg::COUNT_BITS_DEF,
    parameter int PERIOD_BITS = lpjs_pkg::PERIOD_BITS_DEF,
    parameter int FRAC_BITS   = lpjs_pkg::FRAC_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lpjs_in_if.sink      i_in,
    lpjs_out_if.source   o_out,
    lpjs_cfg_if.sink     i_cfg
);
    localparam int VB       = lpjs_pkg::VALUE_BITS;
    localparam int WB       = lpjs_pkg::VAR_BITS;
    localparam int DIV_BITS = COUNT_BITS + 1;
    localparam int MB       = (DIV_BITS > VB) ? DIV_BITS : VB;
    localparam int PW       = VB + MB;
    localparam logic [31:0] CNT_MASK = 32'((64'(1) << COUNT_BITS) - 64'(1));

    lpjs_pkg::t_state                  r_state;
    lpjs_pkg::t_state                  n_state;

    logic [VB-1:0]                     r_nominal;
    logic [lpjs_pkg::SC_BITS-1:0]      r_sample_count;
    logic                              r_active;
    logic [COUNT_BITS-1:0]             r_count_index;

    logic [VB-1:0]                     r_mean;
    logic [VB-1:0]                     r_min;
    logic [VB-1:0]                     r_max;
    logic [COUNT_BITS-1:0]             r_where_min;
    logic [COUNT_BITS-1:0]             r_where_max;
    logic [WB-1:0]                     r_var;

    logic [VB-1:0]                     r_t;
    logic [COUNT_BITS-1:0]             r_i;
    logic                              r_fin;
    logic                              r_neg;
    logic [VB-1:0]                     r_step;
    logic [WB-1:0]                     r_d2;
    logic [PW-1:0]                     r_plo;
    logic [PW-1:0]                     r_phi;
    logic [WB-1:0]                     r_term;
    logic [VB-1:0]                     r_sd;

    logic                              r_out_valid;
    logic [COUNT_BITS-1:0]             r_out_index;
    logic [VB-1:0]                     r_out_mean;
    logic [VB-1:0]                     r_out_min;
    logic [COUNT_BITS-1:0]             r_out_min_index;
    logic [VB-1:0]                     r_out_max;
    logic [COUNT_BITS-1:0]             r_out_max_index;
    logic [VB-1:0]                     r_out_sd;
    logic                              r_out_last;

    logic                              w_in_acc;
    logic                              w_go;
    logic                              w_load;
    logic [WB-1:0]                     w_t_full;
    logic [VB-1:0]                     w_t_sat;
    logic                              w_start_neg;
    logic [VB-1:0]                     w_diff;
    logic [DIV_BITS-1:0]               w_div_plus;
    logic [DIV_BITS-1:0]               w_div_var;
    logic [VB-1:0]                     w_ma;
    logic [MB-1:0]                     w_mb;
    logic [PW-1:0]                     w_prod;
    logic [PW:0]                       w_hi_sum;
    logic                              w_term_ovf;
    logic [WB:0]                       w_vsum;

    lpjs_pkg::t_div_req                w_div_req;
    logic [WB-1:0]                     w_div_dividend;
    logic [DIV_BITS-1:0]               w_div_divisor;
    logic                              w_div_done;
    logic [WB-1:0]                     w_div_quo;
    logic                              w_sqrt_start;
    logic                              w_sqrt_done;
    logic [VB-1:0]                     w_sqrt_root;

    // input side
    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_go     = w_in_acc && (i_in.opcode == lpjs_pkg::OP_SAMPLE) && r_active
                      && (32'(r_count_index) <= 32'(r_sample_count));
    assign w_t_full = WB'(i_in.period[PERIOD_BITS-1:0]) << FRAC_BITS;
    assign w_t_sat  = (|w_t_full[WB-1:VB]) ? '1 : w_t_full[VB-1:0];

    // mean step operands
    assign w_start_neg = (r_t < r_mean);
    assign w_diff      = w_start_neg ? (r_mean - r_t) : (r_t - r_mean);
    assign w_div_plus  = DIV_BITS'(r_i) + DIV_BITS'(1);
    assign w_div_var   = (r_i == '0) ? DIV_BITS'(1) : DIV_BITS'(r_i);

    // shared multiplier
    always_comb begin
        case (r_state)
            lpjs_pkg::ST_SQR: begin
                w_ma = r_step;
                w_mb = MB'(r_step);
            end
            lpjs_pkg::ST_MUL_LO: begin
                w_ma = r_d2[VB-1:0];
                w_mb = MB'(w_div_plus);
            end
            default: begin
                w_ma = r_d2[WB-1:VB];
                w_mb = MB'(w_div_plus);
            end
        endcase
    end
    assign w_prod = PW'(w_ma) * PW'(w_mb);

    assign w_hi_sum   = (PW+1)'(r_plo >> VB) + (PW+1)'(r_phi[VB-1:0]);
    assign w_term_ovf = (|r_phi[PW-1:VB]) || (|w_hi_sum[PW:VB]);
    assign w_vsum     = (WB+1)'(r_var) + (WB+1)'(r_term);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpjs_pkg::ST_IDLE:     if (w_go) n_state = lpjs_pkg::ST_START;
            lpjs_pkg::ST_START:    n_state = lpjs_pkg::ST_MEAN_DIV;
            lpjs_pkg::ST_MEAN_DIV: if (w_div_done) n_state = lpjs_pkg::ST_SQR;
            lpjs_pkg::ST_SQR:      n_state = lpjs_pkg::ST_MUL_LO;
            lpjs_pkg::ST_MUL_LO:   n_state = lpjs_pkg::ST_MUL_HI;
            lpjs_pkg::ST_MUL_HI:   n_state = lpjs_pkg::ST_VAR_DIV;
            lpjs_pkg::ST_VAR_DIV:  if (w_div_done) n_state = lpjs_pkg::ST_VAR_ADD;
            lpjs_pkg::ST_VAR_ADD:  n_state = r_fin ? lpjs_pkg::ST_SQRT_GO : lpjs_pkg::ST_DONE;
            lpjs_pkg::ST_SQRT_GO:  n_state = lpjs_pkg::ST_SQRT;
            lpjs_pkg::ST_SQRT:     if (w_sqrt_done) n_state = lpjs_pkg::ST_DONE;
            lpjs_pkg::ST_DONE:     if (w_load) n_state = lpjs_pkg::ST_IDLE;
            default:               n_state = lpjs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_in.ready       = 1'b0;
        w_div_req.start  = 1'b0;
        w_div_req.half   = 1'b0;
        w_div_dividend   = r_var;
        w_div_divisor    = w_div_var;
        w_sqrt_start     = 1'b0;
        w_load           = 1'b0;
        unique case (r_state)
            lpjs_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            lpjs_pkg::ST_START: begin
                w_div_req.start = 1'b1;
                w_div_req.half  = 1'b1;
                w_div_dividend  = WB'(w_diff);
                w_div_divisor   = w_div_plus;
            end
            lpjs_pkg::ST_MUL_HI: begin
                w_div_req.start = 1'b1;
            end
            lpjs_pkg::ST_SQRT_GO: begin
                w_sqrt_start = 1'b1;
            end
            lpjs_pkg::ST_DONE: begin
                w_load = !r_out_valid || o_out.ready;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lpjs_pkg::ST_IDLE;
            r_nominal      <= lpjs_pkg::NOMINAL_RESET;
            r_sample_count <= lpjs_pkg::SAMPLE_COUNT_RESET & CNT_MASK[lpjs_pkg::SC_BITS-1:0];
            r_active       <= 1'b0;
            r_count_index  <= COUNT_BITS'(1);
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    lpjs_pkg::CFG_NOMINAL: r_nominal <= i_cfg.data;
                    lpjs_pkg::CFG_COUNT:   r_sample_count <=
                        i_cfg.data[lpjs_pkg::SC_BITS-1:0] & CNT_MASK[lpjs_pkg::SC_BITS-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc && (i_in.opcode == lpjs_pkg::OP_ARM)) begin
                r_active      <= 1'b1;
                r_count_index <= COUNT_BITS'(1);
            end
            if (w_load) begin
                r_count_index <= r_i + COUNT_BITS'(1);
                if (r_fin) begin
                    r_active <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.opcode == lpjs_pkg::OP_ARM)) begin
            r_mean      <= r_nominal;
            r_min       <= r_nominal;
            r_max       <= r_nominal;
            r_var       <= '0;
            r_where_min <= '0;
            r_where_max <= '0;
        end
        unique case (r_state)
            lpjs_pkg::ST_IDLE: begin
                if (w_go) begin
                    r_t   <= w_t_sat;
                    r_i   <= r_count_index;
                    r_fin <= (32'(r_count_index) == 32'(r_sample_count));
                end
            end
            lpjs_pkg::ST_START: begin
                r_neg <= w_start_neg;
                if (r_t > r_max) begin
                    r_max       <= r_t;
                    r_where_max <= r_i;
                end
                if (r_t < r_min) begin
                    r_min       <= r_t;
                    r_where_min <= r_i;
                end
            end
            lpjs_pkg::ST_MEAN_DIV: begin
                if (w_div_done) begin
                    r_step <= w_div_quo[VB-1:0];
                    r_mean <= r_neg ? (r_mean - w_div_quo[VB-1:0])
                                    : (r_mean + w_div_quo[VB-1:0]);
                end
            end
            lpjs_pkg::ST_SQR:    r_d2  <= w_prod[WB-1:0];
            lpjs_pkg::ST_MUL_LO: r_plo <= w_prod;
            lpjs_pkg::ST_MUL_HI: r_phi <= w_prod;
            lpjs_pkg::ST_VAR_DIV: begin
                r_term <= w_term_ovf ? '1 : {w_hi_sum[VB-1:0], r_plo[VB-1:0]};
                if (w_div_done) begin
                    r_var <= r_var - w_div_quo;
                end
            end
            lpjs_pkg::ST_VAR_ADD: begin
                r_var <= w_vsum[WB] ? '1 : w_vsum[WB-1:0];
            end
            lpjs_pkg::ST_SQRT: begin
                if (w_sqrt_done) begin
                    r_sd <= w_sqrt_root;
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_out_index     <= r_i;
            r_out_mean      <= r_mean;
            r_out_min       <= r_min;
            r_out_min_index <= r_where_min;
            r_out_max       <= r_max;
            r_out_max_index <= r_where_max;
            r_out_sd        <= r_fin ? r_sd : '0;
            r_out_last      <= r_fin;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample_index = r_out_index;
    assign o_out.mean_period  = r_out_mean;
    assign o_out.min_period   = r_out_min;
    assign o_out.min_index    = r_out_min_index;
    assign o_out.max_period   = r_out_max;
    assign o_out.max_index    = r_out_max_index;
    assign o_out.std_dev      = r_out_sd;
    assign o_out.last         = r_out_last;

    lpjs_div #(
        .DIV_BITS (DIV_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    lpjs_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_sqrt_start),
        .i_operand (r_var),
        .o_done    (w_sqrt_done),
        .o_root    (w_sqrt_root)
    );

    `LPJS_ASSERT_IMPLY(a_div_done_in_wait, i_clk, i_rst_n, w_div_done, (r_state == lpjs_pkg::ST_MEAN_DIV || r_state == lpjs_pkg::ST_VAR_DIV))
    `LPJS_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, (w_load && r_fin), (!r_active && r_out_last))
    `LPJS_ASSERT_IMPLY(a_mean_in_range, i_clk, i_rst_n, (r_active && r_state == lpjs_pkg::ST_IDLE), (r_min <= r_mean && r_mean <= r_max))
endmodule
`default_nettype wire
